FILE: rtl/core/qpj_pkg.sv
// shared types, constants and rounding helpers for the pose point jacobian core
package qpj_pkg;

	localparam int unsigned LATENCY = 6;

	localparam logic signed [31:0] Q_ONE = 32'sd65536;

	typedef enum logic [2:0] {
		DOF_TX   = 3'd0,
		DOF_TY   = 3'd1,
		DOF_TZ   = 3'd2,
		DOF_QW   = 3'd3,
		DOF_QX   = 3'd4,
		DOF_QY   = 3'd5,
		DOF_QZ   = 3'd6,
		DOF_BAD  = 3'd7
	} dof_t;

	typedef enum logic [2:0] {
		REG_QW = 3'd0,
		REG_QX = 3'd1,
		REG_QY = 3'd2,
		REG_QZ = 3'd3,
		REG_SX = 3'd4,
		REG_SY = 3'd5,
		REG_SZ = 3'd6
	} reg_idx_t;

	typedef logic signed [17:0] quat_t;
	typedef logic signed [31:0] fix_t;
	typedef logic signed [32:0] diff_t;
	typedef logic signed [35:0] qprod_t;
	typedef logic signed [22:0] rot_t;
	typedef logic signed [55:0] rprod_t;
	typedef logic signed [41:0] mdl_t;
	typedef logic signed [59:0] dprod_t;

	typedef struct packed {
		logic vld;
		dof_t dof;
	} ctl_t;

	// nearest, ties towards plus infinity
	function automatic logic signed [63:0] rnd16(input logic signed [63:0] v);
		logic signed [63:0] t;
		t = v + 64'sd32768;
		return t >>> 16;
	endfunction

	function automatic fix_t sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647)
			return 32'sh7fffffff;
		else if (v < -64'sd2147483648)
			return 32'sh80000000;
		else
			return v[31:0];
	endfunction

endpackage

FILE: rtl/core/quaternion_pose_point_jacobian_core.sv
// top level: pose registers and the six-stage jacobian pipeline
// One point and degree-of-freedom index enter per clock; busy never rises. The result for
// each beat appears with done high for one cycle, in the order the beats were taken.
// The pipeline steps are quaternion products, rotation matrix, matrix-point products,
// model point, derivative products, then rounding and saturation, one register stage
// each. The receiver cannot stall and has to take each result in its cycle. The user
// must write pose registers through wr_en, wr_index and wr_data only while no beat is
// in flight; the block itself does not enforce this. An unused index is ignored.
module quaternion_pose_point_jacobian_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  qpj_pkg::fix_t       point_x,
	input  qpj_pkg::fix_t       point_y,
	input  qpj_pkg::fix_t       point_z,
	input  logic [2:0]          dof_index,
	output logic                done,
	output qpj_pkg::fix_t       deriv_x,
	output qpj_pkg::fix_t       deriv_y,
	output qpj_pkg::fix_t       deriv_z,
	output logic                bad_index,
	input  logic                wr_en,
	input  logic [2:0]          wr_index,
	input  logic [31:0]         wr_data
);
	import qpj_pkg::*;

	quat_t quat_q [4];
	fix_t  shift_q [3];
	ctl_t  ctl_in, ctl_a, ctl_b;
	fix_t  pt [3];
	diff_t d_a [3];
	quat_t q_a [4];
	quat_t q_b [4];
	rot_t  r_a [9];
	mdl_t  p_b [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quat_q[0]  <= 18'sd65536;
			quat_q[1]  <= '0;
			quat_q[2]  <= '0;
			quat_q[3]  <= '0;
			shift_q[0] <= '0;
			shift_q[1] <= '0;
			shift_q[2] <= '0;
		end else if (wr_en) begin
			case (reg_idx_t'(wr_index))
				REG_QW:  quat_q[0]  <= wr_data[17:0];
				REG_QX:  quat_q[1]  <= wr_data[17:0];
				REG_QY:  quat_q[2]  <= wr_data[17:0];
				REG_QZ:  quat_q[3]  <= wr_data[17:0];
				REG_SX:  shift_q[0] <= wr_data;
				REG_SY:  shift_q[1] <= wr_data;
				REG_SZ:  shift_q[2] <= wr_data;
				default: ;
			endcase
		end
	end

	assign busy       = 1'b0;
	assign ctl_in.vld = start;
	assign ctl_in.dof = dof_t'(dof_index);
	assign pt[0]      = point_x;
	assign pt[1]      = point_y;
	assign pt[2]      = point_z;

	qpj_rot u_rot (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl_in  (ctl_in),
		.pt_in   (pt),
		.shift   (shift_q),
		.quat    (quat_q),
		.ctl_out (ctl_a),
		.d_out   (d_a),
		.q_out   (q_a),
		.r_out   (r_a)
	);

	qpj_bp u_bp (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl_in  (ctl_a),
		.d_in    (d_a),
		.q_in    (q_a),
		.r_in    (r_a),
		.ctl_out (ctl_b),
		.q_out   (q_b),
		.p_out   (p_b)
	);

	qpj_der u_der (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl_in    (ctl_b),
		.q_in      (q_b),
		.p_in      (p_b),
		.done      (done),
		.deriv_x   (deriv_x),
		.deriv_y   (deriv_y),
		.deriv_z   (deriv_z),
		.bad_index (bad_index)
	);

endmodule

FILE: rtl/core/qpj_rot.sv
// stages 1-2: translation removal, quaternion products and rotation matrix
module qpj_rot (
	input  logic           clk,
	input  logic           arst_n,
	input  qpj_pkg::ctl_t  ctl_in,
	input  qpj_pkg::fix_t  pt_in [3],
	input  qpj_pkg::fix_t  shift [3],
	input  qpj_pkg::quat_t quat [4],
	output qpj_pkg::ctl_t  ctl_out,
	output qpj_pkg::diff_t d_out [3],
	output qpj_pkg::quat_t q_out [4],
	output qpj_pkg::rot_t  r_out [9]
);
	import qpj_pkg::*;

	ctl_t   ctl_s1, ctl_s2;
	diff_t  d_s1 [3];
	diff_t  d_s2 [3];
	quat_t  q_s1 [4];
	quat_t  q_s2 [4];
	qprod_t pr_s1 [10];
	rot_t   r_s2 [9];
	rot_t   r_nxt [9];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else begin
			ctl_s1 <= ctl_in;
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			d_s1[i] <= 33'(pt_in[i]) - 33'(shift[i]);
			d_s2[i] <= d_s1[i];
		end
		for (int i = 0; i < 4; i++) begin
			q_s1[i] <= quat[i];
			q_s2[i] <= q_s1[i];
		end
		// ww xx yy zz xy wz xz wy yz wx
		pr_s1[0] <= quat[0] * quat[0];
		pr_s1[1] <= quat[1] * quat[1];
		pr_s1[2] <= quat[2] * quat[2];
		pr_s1[3] <= quat[3] * quat[3];
		pr_s1[4] <= quat[1] * quat[2];
		pr_s1[5] <= quat[0] * quat[3];
		pr_s1[6] <= quat[1] * quat[3];
		pr_s1[7] <= quat[0] * quat[2];
		pr_s1[8] <= quat[2] * quat[3];
		pr_s1[9] <= quat[0] * quat[1];
		r_s2 <= r_nxt;
	end

	always_comb begin
		logic signed [63:0] p [10];
		logic signed [63:0] s [9];
		for (int i = 0; i < 10; i++)
			p[i] = 64'(pr_s1[i]);
		s[0] = p[0] + p[1] - p[2] - p[3];
		s[1] = (p[4] - p[5]) <<< 1;
		s[2] = (p[6] + p[7]) <<< 1;
		s[3] = (p[4] + p[5]) <<< 1;
		s[4] = p[0] - p[1] + p[2] - p[3];
		s[5] = (p[8] - p[9]) <<< 1;
		s[6] = (p[6] - p[7]) <<< 1;
		s[7] = (p[8] + p[9]) <<< 1;
		s[8] = p[0] - p[1] - p[2] + p[3];
		for (int i = 0; i < 9; i++)
			r_nxt[i] = 23'(rnd16(s[i]));
	end

	assign ctl_out = ctl_s2;
	assign d_out   = d_s2;
	assign q_out   = q_s2;
	assign r_out   = r_s2;

endmodule

FILE: rtl/core/qpj_bp.sv
// stages 3-4: inverse rotation of the shifted point into the model frame
module qpj_bp (
	input  logic           clk,
	input  logic           arst_n,
	input  qpj_pkg::ctl_t  ctl_in,
	input  qpj_pkg::diff_t d_in [3],
	input  qpj_pkg::quat_t q_in [4],
	input  qpj_pkg::rot_t  r_in [9],
	output qpj_pkg::ctl_t  ctl_out,
	output qpj_pkg::quat_t q_out [4],
	output qpj_pkg::mdl_t  p_out [3]
);
	import qpj_pkg::*;

	ctl_t   ctl_s3, ctl_s4;
	quat_t  q_s3 [4];
	quat_t  q_s4 [4];
	rprod_t m_s3 [9];
	mdl_t   p_s4 [3];
	mdl_t   p_nxt [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3 <= '0;
			ctl_s4 <= '0;
		end else begin
			ctl_s3 <= ctl_in;
			ctl_s4 <= ctl_s3;
		end
	end

	// transpose: model component i takes column i of the matrix
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				m_s3[i*3+j] <= r_in[j*3+i] * d_in[j];
		q_s3 <= q_in;
		q_s4 <= q_s3;
		p_s4 <= p_nxt;
	end

	always_comb begin
		logic signed [63:0] s;
		for (int i = 0; i < 3; i++) begin
			s = 64'(m_s3[i*3]) + 64'(m_s3[i*3+1]) + 64'(m_s3[i*3+2]);
			p_nxt[i] = 42'(rnd16(s));
		end
	end

	assign ctl_out = ctl_s4;
	assign q_out   = q_s4;
	assign p_out   = p_s4;

endmodule

FILE: rtl/core/qpj_der.sv
// stages 5-6: quaternion partial derivatives, rounding and saturation
module qpj_der (
	input  logic           clk,
	input  logic           arst_n,
	input  qpj_pkg::ctl_t  ctl_in,
	input  qpj_pkg::quat_t q_in [4],
	input  qpj_pkg::mdl_t  p_in [3],
	output logic           done,
	output qpj_pkg::fix_t  deriv_x,
	output qpj_pkg::fix_t  deriv_y,
	output qpj_pkg::fix_t  deriv_z,
	output logic           bad_index
);
	import qpj_pkg::*;

	ctl_t   ctl_s5;
	logic   vld_s6;
	dprod_t m_s5 [12];
	fix_t   a_s6, b_s6, c_s6;
	logic   bad_s6;
	fix_t   a_nxt, b_nxt, c_nxt;
	logic   bad_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s5 <= '0;
			vld_s6 <= 1'b0;
		end else begin
			ctl_s5 <= ctl_in;
			vld_s6 <= ctl_s5.vld;
		end
	end

	// every quaternion component times every model component, index q*3+p
	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++)
			for (int j = 0; j < 3; j++)
				m_s5[i*3+j] <= q_in[i] * p_in[j];
		a_s6   <= a_nxt;
		b_s6   <= b_nxt;
		c_s6   <= c_nxt;
		bad_s6 <= bad_nxt;
	end

	always_comb begin
		logic signed [63:0] t [12];
		logic signed [63:0] sa, sb, sc;
		for (int i = 0; i < 12; i++)
			t[i] = 64'(m_s5[i]);
		sa = '0;
		sb = '0;
		sc = '0;
		a_nxt = '0;
		b_nxt = '0;
		c_nxt = '0;
		bad_nxt = 1'b0;
		// w 0..2, x 3..5, y 6..8, z 9..11
		case (ctl_s5.dof)
			DOF_QW: begin
				sa = (t[8] - t[10]) <<< 1;
				sb = (t[9] - t[5]) <<< 1;
				sc = (t[4] - t[6]) <<< 1;
			end
			DOF_QX: begin
				sa = (t[7] + t[11]) <<< 1;
				sb = ((t[6] - t[2]) <<< 1) - (t[4] <<< 2);
				sc = ((t[9] + t[1]) <<< 1) - (t[5] <<< 2);
			end
			DOF_QY: begin
				sa = ((t[4] + t[2]) <<< 1) - (t[6] <<< 2);
				sb = (t[3] + t[11]) <<< 1;
				sc = ((t[10] - t[0]) <<< 1) - (t[8] <<< 2);
			end
			DOF_QZ: begin
				sa = ((t[5] - t[1]) <<< 1) - (t[9] <<< 2);
				sb = ((t[0] + t[8]) <<< 1) - (t[4] <<< 2);
				sc = (t[3] + t[7]) <<< 1;
			end
			default: begin
			end
		endcase
		case (ctl_s5.dof)
			DOF_TX: a_nxt = Q_ONE;
			DOF_TY: b_nxt = Q_ONE;
			DOF_TZ: c_nxt = Q_ONE;
			DOF_QW, DOF_QX, DOF_QY, DOF_QZ: begin
				a_nxt = sat32(rnd16(sa));
				b_nxt = sat32(rnd16(sb));
				c_nxt = sat32(rnd16(sc));
			end
			default: bad_nxt = 1'b1;
		endcase
	end

	assign done      = vld_s6;
	assign deriv_x   = a_s6;
	assign deriv_y   = b_s6;
	assign deriv_z   = c_s6;
	assign bad_index = bad_s6;

endmodule

FILE: rtl/core/qpj_chk.sv
// port-level checker for the jacobian core and its bind
module qpj_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic [2:0]  dof_index,
	input logic        done,
	input logic [31:0] deriv_x,
	input logic [31:0] deriv_y,
	input logic [31:0] deriv_z,
	input logic        bad_index
);
	import qpj_pkg::*;

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy) else $error("busy raised");

	a_beat_out: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##6 done) else $error("result beat missing");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && bad_index) |-> (deriv_x == '0 && deriv_y == '0 && deriv_z == '0))
		else $error("bad index with nonzero derivative");

	a_tx_unit: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && dof_index == DOF_TX) |-> ##6
		(done && !bad_index && deriv_x == 32'd65536 && deriv_y == '0 && deriv_z == '0))
		else $error("translation x result wrong");

endmodule

bind quaternion_pose_point_jacobian_core qpj_chk u_qpj_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.dof_index (dof_index),
	.done      (done),
	.deriv_x   (deriv_x),
	.deriv_y   (deriv_y),
	.deriv_z   (deriv_z),
	.bad_index (bad_index)
);
